>>> sv/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants, register codes and stage types for the mipmap 2x2
// box-filter downsampler.
// ----------------------------------------------------------------------------
package mbd_pkg;

  // Largest source dimension (log2) and channel count supported
  localparam int MAX_WIDTH_LOG2 = 12;
  localparam int MAX_CHANNELS   = 4;

  // Field and counter widths
  localparam int LOG2_W   = 4;
  localparam int CH_W     = 3;
  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = MAX_WIDTH_LOG2;
  localparam int C_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SAMPLE_W = 8;
  localparam int PAIR_W   = SAMPLE_W + 1;

  // Line buffer of horizontal pair sums, one row of destination pixels
  localparam int RPS_DEPTH = (1 << (MAX_WIDTH_LOG2 - 1)) * MAX_CHANNELS;
  localparam int ADDR_W    = $clog2(RPS_DEPTH);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH_LOG2  = 2'd0,
    CFG_SRC_HEIGHT_LOG2 = 2'd1,
    CFG_CHANNEL_COUNT   = 2'd2,
    CFG_FILTER_MODE     = 2'd3
  } cfg_idx_t;

  // Stream position and decode for the byte at the input
  typedef struct packed {
    logic              wide;   // source width >= 2
    logic              tall;   // source height >= 2
    logic              x_odd;
    logic              y_odd;
    logic [C_W-1:0]    chan;
    logic [ADDR_W-1:0] addr;   // line buffer entry for this column pair
    logic              last;   // final byte of the source level
    logic              avg;    // box average on, else zeros
  } scan_pos_t;

  // Item carried from accept into the result stage
  typedef struct packed {
    logic              emit;
    logic              use_mem;  // add the stored pair sum from the line buffer
    logic              zero;
    logic              last;
    logic [PAIR_W-1:0] pair;
  } stage_t;

endpackage

>>> sv/mbd_line_ram.sv
// ----------------------------------------------------------------------------
// mbd_line_ram
// Single-port synchronous RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module mbd_line_ram #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13,
  parameter int DATA_W = 9
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write or read one entry; read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> sv/mbd_scan.sv
// ----------------------------------------------------------------------------
// mbd_scan
// Configuration registers and the column / row / channel scan counters.
// Decodes the position of the byte at the input and the line buffer address.
// ----------------------------------------------------------------------------
module mbd_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          advance,
  output mbd_pkg::scan_pos_t            pos
);

  logic [mbd_pkg::LOG2_W-1:0] wlog_r, hlog_r;
  logic [mbd_pkg::CH_W-1:0]   chan_cnt_r;
  logic                       mode_r;

  logic [mbd_pkg::CNT_W-1:0]  col_r, col_nxt;
  logic [mbd_pkg::CNT_W-1:0]  row_r, row_nxt;
  logic [mbd_pkg::C_W-1:0]    chan_r, chan_nxt;

  logic [mbd_pkg::LOG2_W-1:0] wl, hl;
  logic [mbd_pkg::CH_W-1:0]   ch_eff;
  logic [mbd_pkg::C_W-1:0]    ch_last;
  logic [mbd_pkg::CNT_W-1:0]  col_last, row_last;
  logic                       at_chan_end, at_col_end, at_row_end;
  logic [mbd_pkg::CNT_W+mbd_pkg::CH_W-1:0] addr_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlog_r     <= '0;
      hlog_r     <= '0;
      chan_cnt_r <= mbd_pkg::CH_W'(1);
      mode_r     <= 1'b1;
    end else if (cfg_we) begin
      case (mbd_pkg::cfg_idx_t'(cfg_index))
        mbd_pkg::CFG_SRC_WIDTH_LOG2:  wlog_r     <= cfg_data;
        mbd_pkg::CFG_SRC_HEIGHT_LOG2: hlog_r     <= cfg_data;
        mbd_pkg::CFG_CHANNEL_COUNT:   chan_cnt_r <= cfg_data[mbd_pkg::CH_W-1:0];
        mbd_pkg::CFG_FILTER_MODE:     mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate sizes and channel count
  always_comb begin
    wl = (wlog_r > mbd_pkg::LOG2_W'(mbd_pkg::MAX_WIDTH_LOG2)) ?
         mbd_pkg::LOG2_W'(mbd_pkg::MAX_WIDTH_LOG2) : wlog_r;
    hl = (hlog_r > mbd_pkg::LOG2_W'(mbd_pkg::MAX_WIDTH_LOG2)) ?
         mbd_pkg::LOG2_W'(mbd_pkg::MAX_WIDTH_LOG2) : hlog_r;
    if (chan_cnt_r == '0) begin
      ch_eff = mbd_pkg::CH_W'(1);
    end else if (chan_cnt_r > mbd_pkg::CH_W'(mbd_pkg::MAX_CHANNELS)) begin
      ch_eff = mbd_pkg::CH_W'(mbd_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = chan_cnt_r;
    end
    ch_last  = mbd_pkg::C_W'(ch_eff - mbd_pkg::CH_W'(1));
    col_last = ~({mbd_pkg::CNT_W{1'b1}} << wl);
    row_last = ~({mbd_pkg::CNT_W{1'b1}} << hl);
  end

  // Position flags and line buffer address
  always_comb begin
    at_chan_end = (chan_r == ch_last);
    at_col_end  = (col_r == col_last);
    at_row_end  = (row_r == row_last);
    addr_full   = {{mbd_pkg::CH_W{1'b0}}, col_r >> 1} *
                  {{mbd_pkg::CNT_W{1'b0}}, ch_eff} +
                  {{(mbd_pkg::CNT_W + mbd_pkg::CH_W - mbd_pkg::C_W){1'b0}}, chan_r};

    pos.wide  = (wl != '0);
    pos.tall  = (hl != '0);
    pos.x_odd = col_r[0];
    pos.y_odd = row_r[0];
    pos.chan  = chan_r;
    pos.addr  = addr_full[mbd_pkg::ADDR_W-1:0];
    pos.last  = at_chan_end && at_col_end && at_row_end;
    pos.avg   = mode_r;
  end

  // Advance channel, then column, then row; wrap at the end of the frame
  always_comb begin
    chan_nxt = chan_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (advance) begin
      if (!at_chan_end) begin
        chan_nxt = chan_r + mbd_pkg::C_W'(1);
      end else begin
        chan_nxt = '0;
        if (!at_col_end) begin
          col_nxt = col_r + mbd_pkg::CNT_W'(1);
        end else begin
          col_nxt = '0;
          row_nxt = at_row_end ? '0 : row_r + mbd_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Any register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
    end
  end

endmodule

>>> sv/mbd_out.sv
// ----------------------------------------------------------------------------
// mbd_out
// Result stage: registers each item alongside its line buffer read, forms the
// average (zeros in zero mode) and holds it in the output register.
// ----------------------------------------------------------------------------
module mbd_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_fire,
  input  mbd_pkg::stage_t              item,
  output logic                         item_ready,
  input  logic [mbd_pkg::PAIR_W-1:0]   mem_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mbd_pkg::SAMPLE_W-1:0] out_value,
  output logic                         out_last
);

  logic                          b_valid_r, b_valid_nxt;
  mbd_pkg::stage_t               b_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [mbd_pkg::SAMPLE_W-1:0]  out_value_r;
  logic                          out_last_r;

  logic                          out_free, b_go;
  logic [mbd_pkg::PAIR_W:0]      quad_sum;
  logic [mbd_pkg::SAMPLE_W-1:0]  value;

  // Handshake between stage and output register
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    b_go       = b_valid_r && (!b_r.emit || out_free);
    item_ready = !b_valid_r || b_go;
  end

  // Form the result byte
  always_comb begin
    quad_sum = {1'b0, mem_rdata} + {1'b0, b_r.pair};
    if (b_r.zero) begin
      value = '0;
    end else if (b_r.use_mem) begin
      value = quad_sum[mbd_pkg::PAIR_W:2];
    end else begin
      value = b_r.pair[mbd_pkg::PAIR_W-1:1];
    end
  end

  // Next valid state for stage and output
  always_comb begin
    b_valid_nxt = item_fire ? 1'b1 : (b_go ? 1'b0 : b_valid_r);
    if (b_go && b_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_fire) begin
      b_r <= item;
    end
    if (b_go && b_r.emit) begin
      out_value_r <= value;
      out_last_r  <= b_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/mipmap_box_downsample.sv
// ----------------------------------------------------------------------------
// mipmap_box_downsample
// 2x2 box-filter mipmap reduction of one level streamed as interleaved bytes.
// ----------------------------------------------------------------------------
// Feed one source level row-major, one channel byte per transfer; the block
// takes one byte every cycle unless the output stalls; each destination byte is
// registered after the source byte that completes it (a bottom-right byte of a
// 2x2 block, or the second byte of a pair when one dimension is 1). One byte
// per cycle is set by the single-port line buffer, which sees exactly one
// write (even rows) or one read (odd rows) per odd-column byte of a box. A 1x1
// source gives no output. Any configuration write restarts the frame; write
// only while the block is idle. The line buffer needs no clearing after reset.
module mipmap_box_downsample (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mbd_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mbd_pkg::SAMPLE_W-1:0]   out_value,
  output logic                           out_last
);

  mbd_pkg::scan_pos_t            pos;
  mbd_pkg::stage_t               item;
  logic                          in_fire;
  logic [mbd_pkg::SAMPLE_W-1:0]  left_r [mbd_pkg::MAX_CHANNELS];
  logic [mbd_pkg::PAIR_W-1:0]    pair;
  logic                          store_left, box, pair_emit;
  logic                          ram_en, ram_we;
  logic [mbd_pkg::PAIR_W-1:0]    ram_rdata;

  assign in_fire = in_valid && in_ready;

  mbd_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_fire),
    .pos       (pos)
  );

  // Decode what this byte does
  always_comb begin
    pair       = {1'b0, left_r[pos.chan]} + {1'b0, in_sample};
    store_left = (pos.wide && !pos.x_odd) || (!pos.wide && pos.tall && !pos.y_odd);
    box        = pos.wide && pos.tall && pos.x_odd;
    pair_emit  = (pos.wide && !pos.tall && pos.x_odd) ||
                 (!pos.wide && pos.tall && pos.y_odd);
    ram_en     = in_fire && box;
    ram_we     = !pos.y_odd;

    item.emit    = pair_emit || (box && pos.y_odd);
    item.use_mem = box;
    item.zero    = !pos.avg;
    item.last    = pos.last;
    item.pair    = pair;
  end

  // Hold the left byte of each pair per channel
  always_ff @(posedge clk) begin
    if (in_fire && store_left) begin
      left_r[pos.chan] <= in_sample;
    end
  end

  mbd_line_ram #(
    .DEPTH  (mbd_pkg::RPS_DEPTH),
    .ADDR_W (mbd_pkg::ADDR_W),
    .DATA_W (mbd_pkg::PAIR_W)
  ) u_line_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (pos.addr),
    .wdata (pair),
    .rdata (ram_rdata)
  );

  mbd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (in_fire),
    .item       (item),
    .item_ready (in_ready),
    .mem_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

>>> test/mipmap_box_downsample_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mipmap_box_downsample_tb
// Self-checking bench for the 2x2 box-filter mipmap downsampler. Streams
// source levels under many size, channel and mode settings, predicts every
// destination byte and its end-of-level flag, and compares each output
// transfer against the oldest prediction while both sides stall at random.
// ----------------------------------------------------------------------------
module mipmap_box_downsample_tb;

  localparam int RUN_LIMIT  = 400000;
  localparam int IDLE_PCT   = 22;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 550;

  typedef logic [mbd_pkg::SAMPLE_W-1:0] sample_q_t [$];

  typedef struct {
    logic [mbd_pkg::SAMPLE_W-1:0] value;
    logic                         last;
  } dest_byte_t;

  // Level reduction predictor plus the queue of destination bytes still owed
  class mip_scoreboard;
    logic [mbd_pkg::PAIR_W-1:0]   pair_sums  [mbd_pkg::RPS_DEPTH];
    logic [mbd_pkg::SAMPLE_W-1:0] left_bytes [mbd_pkg::MAX_CHANNELS];
    int unsigned         col, row, chan;
    int unsigned         width_reg, height_reg, chan_reg, mode_reg;
    dest_byte_t          owed_q [$];
    int unsigned         mismatches;

    function new();
      width_reg  = 0;
      height_reg = 0;
      chan_reg   = 1;
      mode_reg   = 1;
      col        = 0;
      row        = 0;
      chan       = 0;
      mismatches = 0;
    endfunction

    // Any register write restarts the frame
    function void write_reg(mbd_pkg::cfg_idx_t idx, logic [mbd_pkg::CFG_W-1:0] data);
      case (idx)
        mbd_pkg::CFG_SRC_WIDTH_LOG2:  width_reg  = 32'(data[mbd_pkg::LOG2_W-1:0]);
        mbd_pkg::CFG_SRC_HEIGHT_LOG2: height_reg = 32'(data[mbd_pkg::LOG2_W-1:0]);
        mbd_pkg::CFG_CHANNEL_COUNT:   chan_reg   = 32'(data[mbd_pkg::CH_W-1:0]);
        mbd_pkg::CFG_FILTER_MODE:     mode_reg   = 32'(data[0]);
        default: ;
      endcase
      col  = 0;
      row  = 0;
      chan = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Advance the stream position by one accepted source byte
    function void note_sample(logic [mbd_pkg::SAMPLE_W-1:0] s);
      int unsigned w, h, nch, x, y, c, a, avg;
      bit          emit;
      dest_byte_t  d;
      w   = 1 << ((width_reg > mbd_pkg::MAX_WIDTH_LOG2) ? mbd_pkg::MAX_WIDTH_LOG2 : width_reg);
      h   = 1 << ((height_reg > mbd_pkg::MAX_WIDTH_LOG2) ?
                  mbd_pkg::MAX_WIDTH_LOG2 : height_reg);
      nch = (chan_reg == 0) ? 1 :
            ((chan_reg > mbd_pkg::MAX_CHANNELS) ? mbd_pkg::MAX_CHANNELS : chan_reg);
      x   = (col >= w) ? 0 : col;
      y   = (row >= h) ? 0 : row;
      c   = (chan >= nch) ? 0 : chan;
      emit = 1'b0;
      avg  = 0;

      if (w >= 2 && h >= 2) begin
        // full 2x2 block: even rows store pair sums, odd rows finish them
        if (x[0] == 1'b0) begin
          left_bytes[c] = s;
        end else begin
          a = (x >> 1) * nch + c;
          if (y[0] == 1'b0) begin
            pair_sums[a] = {1'b0, left_bytes[c]} + {1'b0, s};
          end else begin
            avg  = (32'(pair_sums[a]) + 32'(left_bytes[c]) + 32'(s)) >> 2;
            emit = 1'b1;
          end
        end
      end else if (w >= 2) begin
        // single row: horizontal pairs
        if (x[0] == 1'b0) begin
          left_bytes[c] = s;
        end else begin
          avg  = (32'(left_bytes[c]) + 32'(s)) >> 1;
          emit = 1'b1;
        end
      end else if (h >= 2) begin
        // single column: vertical pairs
        if (y[0] == 1'b0) begin
          left_bytes[c] = s;
        end else begin
          avg  = (32'(left_bytes[c]) + 32'(s)) >> 1;
          emit = 1'b1;
        end
      end

      if (mode_reg == 0) avg = 0;
      d.value = avg[mbd_pkg::SAMPLE_W-1:0];
      d.last  = (x == w - 1) && (y == h - 1) && (c == nch - 1);

      // wrap channel, then column, then row
      c++;
      if (c >= nch) begin
        c = 0;
        x++;
        if (x >= w) begin
          x = 0;
          y++;
          if (y >= h) y = 0;
        end
      end
      col  = x;
      row  = y;
      chan = c;

      if (emit) owed_q.push_back(d);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    function void check_result(logic [mbd_pkg::SAMPLE_W-1:0] value, logic last);
      dest_byte_t d;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected output value=%0d last=%0b", value, last));
        return;
      end
      d = owed_q.pop_front();
      if (value !== d.value)
        flag($sformatf("value expected %0d, got %0d", d.value, value));
      if (last !== d.last)
        flag($sformatf("last expected %0b, got %0b", d.last, last));
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index = mbd_pkg::CFG_SRC_WIDTH_LOG2;
  logic [mbd_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [mbd_pkg::SAMPLE_W-1:0]  in_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [mbd_pkg::SAMPLE_W-1:0]  out_value;
  logic                          out_last;

  mip_scoreboard sb = new();
  bit            calm = 1'b0;      // no idling on either side while set
  int unsigned   hold_reqs = 0;    // bumped to ask the receiver for a long stall
  int unsigned   cycle_count = 0;

  mipmap_box_downsample dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check each output transfer, then pick ready for the next cycle
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_last);
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one source byte and hold it until the transfer
  task automatic send_byte(input logic [mbd_pkg::SAMPLE_W-1:0] s);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic send_bytes(input sample_q_t src_bytes);
    foreach (src_bytes[i]) send_byte(src_bytes[i]);
    in_valid <= 1'b0;
  endtask

  // Wait for every owed byte, then cover a trailing item with no result
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input mbd_pkg::cfg_idx_t idx,
                           input logic [mbd_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_setting(input logic [mbd_pkg::CFG_W-1:0] wl, hl, chn, fm);
    write_reg(mbd_pkg::CFG_SRC_WIDTH_LOG2, wl);
    write_reg(mbd_pkg::CFG_SRC_HEIGHT_LOG2, hl);
    write_reg(mbd_pkg::CFG_CHANNEL_COUNT, chn);
    write_reg(mbd_pkg::CFG_FILTER_MODE, fm);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [mbd_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(99) < 10) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return mbd_pkg::SAMPLE_W'($urandom_range(0, 255));
  endfunction

  initial begin
    sample_q_t   src_bytes;
    int unsigned rand_items, phase, frame, n, nch;
    logic [mbd_pkg::CFG_W-1:0] wl, hl, chn, fm;
    rand_items = 0;
    phase      = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // 1x1 source straight out of reset: bytes consumed, nothing emitted
    src_bytes = '{8'h00, 8'hFF};
    send_bytes(src_bytes);
    settle();

    // 2x2 at full scale, then wrap into a second frame of zeros
    program_setting(4'd1, 4'd1, 4'd1, 4'd1);
    src_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(src_bytes);
    settle();

    // zero mode on a full-scale block
    program_setting(4'd1, 4'd1, 4'd1, 4'd0);
    src_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_bytes(src_bytes);
    settle();

    // single row, channel count 0 taken as 1
    program_setting(4'd1, 4'd0, 4'd0, 4'd1);
    src_bytes = '{8'hFF, 8'hFE};
    send_bytes(src_bytes);
    settle();

    // single column, channel count 7 saturated to four
    program_setting(4'd0, 4'd1, 4'd7, 4'd1);
    src_bytes = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'hFF, 8'h01, 8'h00};
    send_bytes(src_bytes);
    settle();

    // restart mid-frame: three bytes, rewrite, then a whole frame
    program_setting(4'd1, 4'd1, 4'd1, 4'd1);
    src_bytes = '{8'h10, 8'h20, 8'h30};
    send_bytes(src_bytes);
    settle();
    program_setting(4'd1, 4'd1, 4'd1, 4'd1);
    src_bytes = '{8'h03, 8'h05, 8'h07, 8'h0B};
    send_bytes(src_bytes);
    settle();

    // random small levels, whole frames with the odd partial tail
    while (rand_items < RAND_ITEMS || phase < 4) begin
      phase++;
      wl  = mbd_pkg::CFG_W'($urandom_range(0, 3));
      hl  = mbd_pkg::CFG_W'($urandom_range(0, 3));
      chn = mbd_pkg::CFG_W'($urandom_range(0, 7));
      fm  = ($urandom_range(99) < 15) ? 4'd0 : 4'd1;
      if (phase == 4) begin
        // long receiver stall while a busy level keeps coming
        wl  = 4'd3;
        hl  = 4'd2;
        chn = 4'd4;
        fm  = 4'd1;
      end
      nch   = (chn == 0) ? 1 :
              ((32'(chn) > mbd_pkg::MAX_CHANNELS) ? mbd_pkg::MAX_CHANNELS : 32'(chn));
      frame = (1 << wl) * (1 << hl) * nch;
      n     = frame * $urandom_range(1, 2);
      if (phase == 4) n = frame * 2;
      else if ($urandom_range(99) < 30) n += $urandom_range(1, frame);

      program_setting(wl, hl, mbd_pkg::CFG_W'(chn | ($urandom_range(0, 1) << 3)),
                      mbd_pkg::CFG_W'(fm | ($urandom_range(0, 7) << 1)));
      src_bytes.delete();
      repeat (n) src_bytes.push_back(pick_sample());
      if (phase == 4) hold_reqs++;
      send_bytes(src_bytes);
      settle();
      if (wl != 0 || hl != 0) rand_items += n;
    end

    // larger levels at full rate
    calm = 1'b1;

    // wide rows with four channels: one whole frame
    program_setting(4'd5, 4'd1, 4'd4, 4'd1);
    src_bytes.delete();
    repeat ((1 << 5) * 2 * mbd_pkg::MAX_CHANNELS) src_bytes.push_back(pick_sample());
    send_bytes(src_bytes);
    settle();

    // oversized width saturates: head of a single-row frame
    program_setting(4'd15, 4'd0, 4'd1, 4'd1);
    src_bytes.delete();
    repeat (64) src_bytes.push_back(pick_sample());
    send_bytes(src_bytes);
    settle();

    calm = 1'b0;

    // tallest column, oversized height, zero mode: head of the frame only
    program_setting(4'd0, 4'd13, 4'd1, 4'd0);
    src_bytes.delete();
    repeat (64) src_bytes.push_back(pick_sample());
    send_bytes(src_bytes);
    settle();

    // height at the top of range with a narrow 2x2 layout
    program_setting(4'd1, 4'd12, 4'd2, 4'd1);
    src_bytes.delete();
    repeat (96) src_bytes.push_back(pick_sample());
    send_bytes(src_bytes);
    settle();

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mbd_pkg.sv
sv/mbd_line_ram.sv
sv/mbd_scan.sv
sv/mbd_out.sv
sv/mipmap_box_downsample.sv
test/mipmap_box_downsample_tb.sv
